FILE: rtl/prmv_pkg.sv
`default_nettype none

package prmv_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned ScoreW = 16;
  localparam int unsigned PosW   = 6;
  localparam int unsigned RatioW = 8;
  localparam int unsigned ProdW  = ScoreW + RatioW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_RATIO_NUM   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RATIO_DEN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PEAK_RADIUS = 2'd2;

  // Register reset values
  localparam logic [RatioW-1:0] RATIO_NUM_RST   = 8'd4;
  localparam logic [RatioW-1:0] RATIO_DEN_RST   = 8'd5;
  localparam logic [PosW-1:0]   PEAK_RADIUS_RST = 6'd15;

  // Input request: one candidate score
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              last;
  } in_t;

  // Output request: one line verdict
  typedef struct packed {
    logic [PosW-1:0] peak_index;
    logic            match_valid;
  } out_t;

  // Line summary passed from tracker to evaluator
  typedef struct packed {
    logic [ScoreW-1:0] best_score;
    logic [PosW-1:0]   best_pos;
    logic [ScoreW-1:0] runner_score;
    logic [PosW-1:0]   runner_pos;
  } summary_t;

  // Configuration register set
  typedef struct packed {
    logic [RatioW-1:0] ratio_num;
    logic [RatioW-1:0] ratio_den;
    logic [PosW-1:0]   peak_radius;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/prmv_front.sv
`default_nettype none

module prmv_front #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  input  wire                logic in_stall,
  input  wire prmv_pkg::in_t in_data,
  output logic               push,
  output prmv_pkg::summary_t push_data
);

  localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);

  logic [prmv_pkg::ScoreW-1:0] best_score_r, best_score_nxt;
  logic [prmv_pkg::PosW-1:0]   best_pos_r, best_pos_nxt;
  logic [prmv_pkg::ScoreW-1:0] runner_score_r, runner_score_nxt;
  logic [prmv_pkg::PosW-1:0]   runner_pos_r, runner_pos_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic                        accept;
  logic                        in_window;
  logic [prmv_pkg::PosW-1:0]   pos;

  assign accept    = in_valid && !in_stall;
  assign in_window = cnt_r < CntW'(WINDOW_MAX);
  assign pos       = prmv_pkg::PosW'(cnt_r);

  // Top-two tracking; ties keep the earlier position
  always_comb begin
    best_score_nxt   = best_score_r;
    best_pos_nxt     = best_pos_r;
    runner_score_nxt = runner_score_r;
    runner_pos_nxt   = runner_pos_r;
    cnt_nxt          = cnt_r;
    if (in_window) begin
      if (in_data.score > best_score_r) begin
        runner_score_nxt = best_score_r;
        runner_pos_nxt   = best_pos_r;
        best_score_nxt   = in_data.score;
        best_pos_nxt     = pos;
      end else if (in_data.score > runner_score_r) begin
        runner_score_nxt = in_data.score;
        runner_pos_nxt   = pos;
      end
      cnt_nxt = cnt_r + CntW'(1);
    end
  end

  // Hand the finished line to the queue
  assign push                   = accept && in_data.last;
  assign push_data.best_score   = best_score_nxt;
  assign push_data.best_pos     = best_pos_nxt;
  assign push_data.runner_score = runner_score_nxt;
  assign push_data.runner_pos   = runner_pos_nxt;

  // State update; a last item clears for the next line
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      best_score_r   <= '0;
      best_pos_r     <= '0;
      runner_score_r <= '0;
      runner_pos_r   <= '0;
      cnt_r          <= '0;
    end else if (accept) begin
      best_score_r   <= best_score_nxt;
      best_pos_r     <= best_pos_nxt;
      runner_score_r <= runner_score_nxt;
      runner_pos_r   <= runner_pos_nxt;
      cnt_r          <= cnt_nxt;
    end
  end

  // A line end always leaves the tracker cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (cnt_r == '0) && (best_score_r == '0) && (runner_score_r == '0))
    else $error("tracker not cleared after last item");

  // Runner never exceeds best
  a_runner_le_best: assert property (@(posedge clk) disable iff (!rst_n)
    runner_score_r <= best_score_r)
    else $error("runner above best");

endmodule

`default_nettype wire

FILE: rtl/prmv_queue.sv
`default_nettype none

module prmv_queue (
  input  wire                     logic clk,
  input  wire                     logic rst_n,
  input  wire                     logic push,
  input  wire prmv_pkg::summary_t push_data,
  input  wire                     logic pop,
  output logic                    full,
  output logic                    q_valid,
  output prmv_pkg::summary_t      q_data
);

  localparam int unsigned Depth = 2;

  prmv_pkg::summary_t mem [Depth];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = cnt_r == 2'(Depth);
  assign q_valid = cnt_r != 2'd0;
  assign q_data  = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Nothing pushed into a full queue or popped from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && !q_valid))
    else $error("queue overflow or underflow");

endmodule

`default_nettype wire

FILE: rtl/prmv_back.sv
`default_nettype none

module prmv_back (
  input  wire                     logic clk,
  input  wire                     logic rst_n,
  input  wire prmv_pkg::cfg_t     cfg,
  input  wire                     logic q_valid,
  input  wire prmv_pkg::summary_t q_data,
  output logic                    pop,
  output logic                    out_valid,
  input  wire                     logic out_stall,
  output prmv_pkg::out_t          out_data
);

  logic                          s1_valid_r;
  logic [prmv_pkg::ProdW-1:0]    lhs_r;
  logic [prmv_pkg::ProdW-1:0]    rhs_r;
  logic [prmv_pkg::PosW-1:0]     pos_r;
  logic                          best_nz_r;
  logic                          runner_lt_r;
  logic                          dist_ok_r;
  logic                          out_valid_r;
  prmv_pkg::out_t                out_r;
  logic                          adv_out;
  logic                          s1_go;
  logic [prmv_pkg::PosW-1:0]     peak_dist;

  assign adv_out = !out_valid_r || !out_stall;
  assign s1_go   = !s1_valid_r || adv_out;
  assign pop     = q_valid && s1_go;

  // Peak distance
  assign peak_dist = (q_data.best_pos >= q_data.runner_pos) ?
                     (q_data.best_pos - q_data.runner_pos) :
                     (q_data.runner_pos - q_data.best_pos);

  // Stage 1: cross products and side tests
  always_ff @(posedge clk) begin
    if (s1_go) begin
      lhs_r       <= prmv_pkg::ProdW'(q_data.runner_score) *
                     prmv_pkg::ProdW'(cfg.ratio_den);
      rhs_r       <= prmv_pkg::ProdW'(q_data.best_score) *
                     prmv_pkg::ProdW'(cfg.ratio_num);
      pos_r       <= q_data.best_pos;
      best_nz_r   <= q_data.best_score != '0;
      runner_lt_r <= q_data.runner_score < q_data.best_score;
      dist_ok_r   <= peak_dist <= cfg.peak_radius;
    end
  end

  // Stage 2: verdict into the output register
  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_r.peak_index  <= pos_r;
      out_r.match_valid <= best_nz_r && (lhs_r >= rhs_r) && runner_lt_r && dist_ok_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_go) begin
        s1_valid_r <= q_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A stage-1 result moves on whenever the output is free
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv_out |=> out_valid_r)
    else $error("stage 1 result lost");

  // A held result is not overwritten
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: rtl/peak_ratio_match_validator.sv
// Peak ratio match validator.
// Input channel (in_valid / in_stall / in_data): one candidate score per
// request, in position order along a line; in_data.last ends the line.
// Output channel (out_valid / out_stall / out_data): one request per line,
// carrying the best position and the match_valid verdict.
// Config port (cfg_we / cfg_index / cfg_data): ratio_num, ratio_den and
// peak_radius; write only while no line is in flight.
// Throughput: one input request per cycle while in_stall is low. The
// tracker updates in the accepting cycle; a two-entry queue separates it
// from the evaluator. The line summary goes into the queue, then into
// stage 1 (queue read and products), then the compare into the output register.
// Reset: clears the tracker, queue and pipeline, and loads ratio 4/5 and
// radius 15. Positions at or past WINDOW_MAX leave the scores unchanged.
// Receiver stall: results hold in the output register and stage 1, then
// in the queue; in_stall rises once the queue holds two finished lines.
`default_nettype none

module peak_ratio_match_validator #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire                                 logic clk,
  input  wire                                 logic rst_n,
  input  wire                                 logic in_valid,
  output logic                                in_stall,
  input  wire prmv_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire                                 logic out_stall,
  output prmv_pkg::out_t                      out_data,
  input  wire                                 logic cfg_we,
  input  wire logic [prmv_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [prmv_pkg::CfgDataW-1:0]  cfg_data
);

  prmv_pkg::cfg_t     cfg_r;
  prmv_pkg::summary_t push_data;
  prmv_pkg::summary_t q_data;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio_num   <= prmv_pkg::RATIO_NUM_RST;
      cfg_r.ratio_den   <= prmv_pkg::RATIO_DEN_RST;
      cfg_r.peak_radius <= prmv_pkg::PEAK_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        prmv_pkg::CFG_RATIO_NUM:   cfg_r.ratio_num   <= cfg_data;
        prmv_pkg::CFG_RATIO_DEN:   cfg_r.ratio_den   <= cfg_data;
        prmv_pkg::CFG_PEAK_RADIUS: cfg_r.peak_radius <= prmv_pkg::PosW'(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  // Front: score tracking
  prmv_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (q_full),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  // Line summary queue
  prmv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Back: ratio and distance tests
  prmv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/tb_peak_ratio_match_validator.sv
`default_nettype none

module tb_peak_ratio_match_validator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_MAX   = 64;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS  = 160;

  // no register lives at this index
  localparam logic [prmv_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef enum int unsigned {
    LINE_NOISE,
    LINE_CLOSE,
    LINE_SPARSE,
    LINE_TINY
  } line_flavor_e;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  prmv_pkg::in_t                 in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  prmv_pkg::out_t                out_data;
  logic                          cfg_we    = 1'b0;
  logic [prmv_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [prmv_pkg::CfgDataW-1:0] cfg_data  = '0;

  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned burst_left   = 0;
  bit          hold_pending = 1'b0;

  // Line tracker mirror and register copy
  logic [prmv_pkg::ScoreW-1:0] trk_best;
  logic [prmv_pkg::PosW-1:0]   trk_best_pos;
  logic [prmv_pkg::ScoreW-1:0] trk_runner;
  logic [prmv_pkg::PosW-1:0]   trk_runner_pos;
  logic [6:0]                  trk_count;
  logic [prmv_pkg::RatioW-1:0] cfg_num;
  logic [prmv_pkg::RatioW-1:0] cfg_den;
  logic [prmv_pkg::PosW-1:0]   cfg_radius;

  prmv_pkg::out_t expected_verdicts[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  peak_ratio_match_validator #(
    .WINDOW_MAX(WINDOW_MAX)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic void clear_tracker();
    trk_best       = '0;
    trk_best_pos   = '0;
    trk_runner     = '0;
    trk_runner_pos = '0;
    trk_count      = '0;
  endfunction

  // Fold one accepted score into the line; queue the verdict on last
  function automatic void track_score(input prmv_pkg::in_t req);
    logic [prmv_pkg::PosW-1:0] pos;
    logic [prmv_pkg::PosW-1:0] peak_dist;
    logic [31:0]               lhs;
    logic [31:0]               rhs;
    logic                      ok;
    prmv_pkg::out_t            verdict;
    if (trk_count < WINDOW_MAX) begin
      pos = trk_count[prmv_pkg::PosW-1:0];
      if (req.score > trk_best) begin
        trk_runner     = trk_best;
        trk_runner_pos = trk_best_pos;
        trk_best       = req.score;
        trk_best_pos   = pos;
      end else if (req.score > trk_runner) begin
        trk_runner     = req.score;
        trk_runner_pos = pos;
      end
      trk_count = trk_count + 1'b1;
    end
    if (req.last) begin
      peak_dist = (trk_best_pos >= trk_runner_pos) ?
                  (trk_best_pos - trk_runner_pos) :
                  (trk_runner_pos - trk_best_pos);
      lhs = 32'(trk_runner) * 32'(cfg_den);
      rhs = 32'(trk_best) * 32'(cfg_num);
      ok  = (trk_best != '0) && (lhs >= rhs) && (trk_runner < trk_best) &&
            (peak_dist <= cfg_radius);
      verdict.peak_index  = trk_best_pos;
      verdict.match_valid = ok;
      expected_verdicts = {expected_verdicts, verdict};
      clear_tracker();
    end
  endfunction

  // Offer one score; sender idles in random bursts and gaps
  task automatic send_score(input logic [prmv_pkg::ScoreW-1:0] score, input logic last);
    prmv_pkg::in_t req;
    int unsigned   gap;
    req.score = score;
    req.last  = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    track_score(req);
  endtask

  // Wait for every queued verdict plus the pipeline tail
  task automatic drain_lines();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers, then poke the unused index
  task automatic program_cfg(input logic [prmv_pkg::RatioW-1:0] num,
                             input logic [prmv_pkg::RatioW-1:0] den,
                             input logic [prmv_pkg::CfgDataW-1:0] radius_raw);
    cfg_we    <= 1'b1;
    cfg_index <= prmv_pkg::CFG_RATIO_NUM;
    cfg_data  <= num;
    @(posedge clk);
    cfg_num    = num;
    cfg_index <= prmv_pkg::CFG_RATIO_DEN;
    cfg_data  <= den;
    @(posedge clk);
    cfg_den    = den;
    cfg_index <= prmv_pkg::CFG_PEAK_RADIUS;
    cfg_data  <= radius_raw;
    @(posedge clk);
    cfg_radius = radius_raw[prmv_pkg::PosW-1:0];
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // One line of random length and score shape
  task automatic send_random_line(inout int unsigned sent);
    int unsigned                 len;
    int unsigned                 pick;
    int unsigned                 base;
    line_flavor_e                flavor;
    logic [prmv_pkg::ScoreW-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 80) len = $urandom_range(1, 10);
    else if (pick < 96) len = $urandom_range(11, WINDOW_MAX);
    else len = $urandom_range(WINDOW_MAX + 1, WINDOW_MAX + 12);
    flavor = line_flavor_e'($urandom_range(0, 3));
    base   = $urandom_range(1, 65535);
    for (int unsigned i = 0; i < len; i++) begin
      case (flavor)
        LINE_NOISE:  s = 16'($urandom);
        LINE_CLOSE:  s = ($urandom_range(0, 7) == 0) ? '0
                                                     : 16'(base - $urandom_range(0, base / 3));
        LINE_SPARSE: s = ($urandom_range(0, 3) == 0) ? 16'($urandom) : '0;
        default:     s = 16'($urandom_range(0, 15));
      endcase
      send_score(s, i == len - 1);
    end
    sent += len;
  endtask

  // Reset register values: lone item, zero best, pass, tie, best moving down
  task automatic test_directed_lines();
    send_score(16'hFFFF, 1'b1);
    send_score(16'd0, 1'b0);
    send_score(16'd0, 1'b1);
    send_score(16'd1000, 1'b0);
    send_score(16'd900, 1'b1);
    send_score(16'd500, 1'b0);
    send_score(16'd500, 1'b1);
    send_score(16'd100, 1'b0);
    send_score(16'd200, 1'b0);
    send_score(16'd190, 1'b1);
    drain_lines();
  endtask

  // Radius limit, zero denominator and ratio extremes
  task automatic test_cfg_extremes();
    program_cfg(prmv_pkg::RATIO_NUM_RST, prmv_pkg::RATIO_DEN_RST, 8'd1);
    send_score(16'd800, 1'b0);
    send_score(16'd0, 1'b0);
    send_score(16'd790, 1'b1);
    send_score(16'd800, 1'b0);
    send_score(16'd790, 1'b1);
    drain_lines();
    program_cfg(8'd0, 8'd0, 8'd15);
    send_score(16'd1000, 1'b0);
    send_score(16'd900, 1'b1);
    drain_lines();
    program_cfg(8'd1, 8'd0, 8'd15);
    send_score(16'd1000, 1'b0);
    send_score(16'd900, 1'b1);
    drain_lines();
    program_cfg(8'd255, 8'd1, 8'd63);
    send_score(16'hFFFF, 1'b0);
    send_score(16'hFFFE, 1'b1);
    drain_lines();
    program_cfg(8'd0, 8'd255, 8'hC0);
    send_score(16'hFFFF, 1'b0);
    send_score(16'd1, 1'b1);
    drain_lines();
  endtask

  // Lines that run to and past the window end
  task automatic test_window_overflow();
    logic [prmv_pkg::ScoreW-1:0] s;
    program_cfg(8'd4, 8'd5, 8'd63);
    // peak beyond the window must be ignored
    for (int unsigned i = 0; i < 70; i++) begin
      if (i == 65) s = 16'hFFFF;
      else if (i == 3) s = 16'd40000;
      else if (i == 60) s = 16'd36000;
      else s = 16'($urandom_range(0, 1000));
      send_score(s, i == 69);
    end
    // exactly a full window, peaks at both ends
    for (int unsigned i = 0; i < WINDOW_MAX; i++) begin
      if (i == WINDOW_MAX - 1) s = 16'hFFFF;
      else if (i == 0) s = 16'd60000;
      else s = 16'($urandom_range(0, 5000));
      send_score(s, i == WINDOW_MAX - 1);
    end
    for (int unsigned i = 0; i < 130; i++) begin
      send_score(16'($urandom), i == 129);
    end
    drain_lines();
  endtask

  // Random lines over several register settings
  task automatic test_random_lines();
    int unsigned                 sent;
    logic [prmv_pkg::RatioW-1:0] num;
    logic [prmv_pkg::RatioW-1:0] den;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      case (phase)
        0: program_cfg(8'd0, 8'd255, 8'd63);
        1: program_cfg(8'd255, 8'd255, 8'd0);
        2: program_cfg(8'd1, 8'd255, 8'hFF);
        default: begin
          den = 8'($urandom_range(1, 255));
          num = 8'($urandom_range(0, den));
          program_cfg(num, den, 8'($urandom));
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_line(sent);
      drain_lines();
    end
  endtask

  // Receiver holds off while short lines keep coming, filling the block
  task automatic test_output_backpressure();
    program_cfg(8'd3, 8'd4, 8'd20);
    hold_pending = 1'b1;
    for (int unsigned i = 0; i < 120; i++) begin
      send_score(16'($urandom), ($urandom_range(0, 1) == 1) || (i == 119));
    end
    drain_lines();
  endtask

  initial begin
    clear_tracker();
    cfg_num    = prmv_pkg::RATIO_NUM_RST;
    cfg_den    = prmv_pkg::RATIO_DEN_RST;
    cfg_radius = prmv_pkg::PEAK_RADIUS_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lines();
    test_cfg_extremes();
    test_window_overflow();
    test_random_lines();
    test_output_backpressure();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver stall pattern, with a long hold on request
  initial begin : rx_stall_gen
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((mode_left % 8) < 3);
        endcase
      end
    end
  end

  // Compare each accepted verdict with the oldest prediction
  always @(posedge clk) begin : verdict_check
    prmv_pkg::out_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected verdict: peak_index %0d, match_valid %0d",
               out_data.peak_index, out_data.match_valid);
        fail_count++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (out_data.peak_index !== exp_v.peak_index) begin
          $error("peak_index mismatch: expected %0d, actual %0d",
                 exp_v.peak_index, out_data.peak_index);
          fail_count++;
        end
        if (out_data.match_valid !== exp_v.match_valid) begin
          $error("match_valid mismatch: expected %0d, actual %0d",
                 exp_v.match_valid, out_data.match_valid);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long with no request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire
